[design/rrpcs_pkg.sv]
// ----------------------------------------------------------------------------
// rrpcs_pkg
// Shared types and codes for the round-robin scheduler with call stacks.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpcs_pkg;

  localparam int MAX_PROCS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int PROC_W = 4;
  localparam int FUNC_W = 8;
  localparam int RES_W  = 3;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETURN = 2'd2;

  localparam logic [RES_W-1:0] EV_ADDED     = 3'd0;
  localparam logic [RES_W-1:0] EV_CALLS     = 3'd1;
  localparam logic [RES_W-1:0] EV_RETURNS   = 3'd2;
  localparam logic [RES_W-1:0] EV_ENDED     = 3'd3;
  localparam logic [RES_W-1:0] EV_EMPTY     = 3'd4;
  localparam logic [RES_W-1:0] EV_DUPLICATE = 3'd5;
  localparam logic [RES_W-1:0] EV_FULL      = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PROC_W-1:0] proc_id;
    logic [FUNC_W-1:0] func_id;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0]  event_res;
    logic [PROC_W-1:0] event_proc;
    logic [FUNC_W-1:0] event_func;
  } evt_t;

endpackage

`default_nettype wire

[design/rrpcs_ram.sv]
// ----------------------------------------------------------------------------
// rrpcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrpcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/round_robin_process_call_stacks.sv]
// ----------------------------------------------------------------------------
// round_robin_process_call_stacks
// Round-robin ready ring of process ids, each process with its own call stack.
// ----------------------------------------------------------------------------
// A command beat is handled in steps: a read of the ready ring memory, then
// decide and write back; a return that pops a function adds a step, as the
// popped id comes from a second read of the call-stack memory.
// The block takes one command at a time and holds off new commands until the
// result has been loaded into the output register. The ring entry carries the
// process id together with its stack level, so no clearing pass is needed after
// reset: only entries written by a start or a rotation are ever read.
`default_nettype none

module round_robin_process_call_stacks #(
  parameter int MAX_PROCS   = rrpcs_pkg::MAX_PROCS_DEF,
  parameter int STACK_DEPTH = rrpcs_pkg::STACK_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire rrpcs_pkg::req_t  req,
  output logic                  evt_valid,
  input  wire logic             evt_stall,
  output rrpcs_pkg::evt_t       evt
);

  localparam int RW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int EW = rrpcs_pkg::PROC_W + LW;
  localparam int SD = MAX_PROCS * STACK_DEPTH;
  localparam int AW = $clog2(SD);
  localparam int PW = rrpcs_pkg::PROC_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]           state, state_next;
  logic [RW-1:0]        ring_head, head_next;
  logic [CW-1:0]        ring_count, count_next;
  logic [MAX_PROCS-1:0] queued, queued_next;
  rrpcs_pkg::req_t      req_q;
  logic [PW-1:0]        pop_proc, pop_proc_next;
  logic                 evt_load;
  rrpcs_pkg::evt_t      evt_next;

  logic                 ring_we, ring_re;
  logic [RW-1:0]        ring_waddr;
  logic [EW-1:0]        ring_wdata, ring_rdata;
  logic                 cs_we, cs_re;
  logic [AW-1:0]        cs_waddr, cs_raddr;
  logic [rrpcs_pkg::FUNC_W-1:0] cs_rdata;

  logic                 accept, out_free;
  logic [PW-1:0]        front_proc;
  logic [LW-1:0]        front_lvl;
  logic [CW:0]          tail_sum, tail_wrap;
  logic [RW-1:0]        ring_tail, head_inc;
  logic [RW-1:0]        pid_idx, front_idx;
  logic                 pid_ok;

  rrpcs_ram #(.WIDTH(EW), .DEPTH(MAX_PROCS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  rrpcs_ram #(.WIDTH(rrpcs_pkg::FUNC_W), .DEPTH(SD)) u_calls (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (req_q.func_id),
    .re    (cs_re),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign ring_re   = accept;
  assign out_free  = !evt_valid || !evt_stall;

  assign front_proc = ring_rdata[PW-1:0];
  assign front_lvl  = ring_rdata[EW-1:PW];
  assign front_idx  = RW'(front_proc);
  assign pid_idx    = RW'(req_q.proc_id);
  assign pid_ok     = 32'(req_q.proc_id) < 32'(MAX_PROCS);

  // tail slot, head + count modulo the ring size
  assign tail_sum  = (CW + 1)'(ring_head) + (CW + 1)'(ring_count);
  assign tail_wrap = (tail_sum >= (CW + 1)'(MAX_PROCS)) ?
                     tail_sum - (CW + 1)'(MAX_PROCS) : tail_sum;
  assign ring_tail = tail_wrap[RW-1:0];
  assign head_inc  = (ring_head == RW'(MAX_PROCS - 1)) ? '0 : ring_head + 1'b1;

  assign cs_waddr = AW'(32'(front_proc) * 32'(STACK_DEPTH) + 32'(front_lvl));
  assign cs_raddr = AW'(32'(front_proc) * 32'(STACK_DEPTH) + 32'(front_lvl) - 32'd1);

  always_comb begin
    state_next    = state;
    head_next     = ring_head;
    count_next    = ring_count;
    queued_next   = queued;
    pop_proc_next = pop_proc;
    ring_we       = 1'b0;
    ring_waddr    = ring_tail;
    ring_wdata    = ring_rdata;
    cs_we         = 1'b0;
    cs_re         = 1'b0;
    evt_load      = 1'b0;
    evt_next      = evt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          evt_load   = 1'b1;
          state_next = S_IDLE;
          if (req_q.cmd == rrpcs_pkg::CMD_START) begin
            evt_next = '{rrpcs_pkg::EV_DUPLICATE, req_q.proc_id, '0};
            if (pid_ok && !queued[pid_idx]) begin
              evt_next.event_res   = rrpcs_pkg::EV_ADDED;
              queued_next[pid_idx] = 1'b1;
              ring_we              = 1'b1;
              ring_wdata           = {LW'(0), req_q.proc_id};
              count_next           = ring_count + 1'b1;
            end
          end else if (ring_count == '0) begin
            evt_next = '{rrpcs_pkg::EV_EMPTY, '0, '0};
          end else if (req_q.cmd == rrpcs_pkg::CMD_RUN) begin
            if (32'(front_lvl) >= 32'(STACK_DEPTH)) begin
              evt_next = '{rrpcs_pkg::EV_FULL, front_proc, '0};
            end else begin
              evt_next   = '{rrpcs_pkg::EV_CALLS, front_proc, req_q.func_id};
              cs_we      = 1'b1;
              ring_we    = 1'b1;
              ring_wdata = {front_lvl + 1'b1, front_proc};
              head_next  = head_inc;
            end
          end else if (front_lvl == '0) begin
            // empty stack on return: process leaves the ring
            evt_next               = '{rrpcs_pkg::EV_ENDED, front_proc, '0};
            queued_next[front_idx] = 1'b0;
            head_next              = head_inc;
            count_next             = ring_count - 1'b1;
          end else begin
            // pop: rotate now, report once the stack read returns
            evt_load      = 1'b0;
            cs_re         = 1'b1;
            ring_we       = 1'b1;
            ring_wdata    = {front_lvl - 1'b1, front_proc};
            head_next     = head_inc;
            pop_proc_next = front_proc;
            state_next    = S_POP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          evt_load   = 1'b1;
          evt_next   = '{rrpcs_pkg::EV_RETURNS, pop_proc, cs_rdata};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ring_head  <= '0;
      ring_count <= '0;
      queued     <= '0;
      evt_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ring_head  <= head_next;
      ring_count <= count_next;
      queued     <= queued_next;
      if (evt_load) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    pop_proc <= pop_proc_next;
    if (evt_load) begin
      evt <= evt_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(MAX_PROCS))
    else $error("ring count beyond ring size");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == 32'(ring_count))
    else $error("queued flags disagree with ring count");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted beat did not move to execute");

  a_pop_origin: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> $past(state) == S_EXEC || $past(state) == S_POP)
    else $error("pop state entered from wrong state");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin scheduler with call stacks. A
// directed opening covers the empty ring, duplicate starts, a full stack and
// the spare command code. Random episodes of starts, calls and returns follow.
// Every accepted command is run through a behavioural copy of the scheduler,
// and each event beat is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int PROCS      = rrpcs_pkg::MAX_PROCS_DEF;
  localparam int DEPTH      = rrpcs_pkg::STACK_DEPTH_DEF;
  localparam int RAND_ITEMS = 600;
  localparam int CYCLE_CAP  = 300000;

  // top selector value, decoded by the block as a return
  localparam logic [rrpcs_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  rrpcs_pkg::req_t req = '0;
  logic evt_valid;
  logic evt_stall = 1'b0;
  rrpcs_pkg::evt_t evt;

  rrpcs_pkg::req_t cmd_backlog [$];
  rrpcs_pkg::evt_t due_events [$];

  // scheduler state as the block should hold it
  logic [rrpcs_pkg::PROC_W-1:0] ready_slot [PROCS];
  logic [rrpcs_pkg::PROC_W-1:0] ring_front;
  logic [4:0]                   ring_live;
  bit                           in_ring [PROCS];
  logic [rrpcs_pkg::FUNC_W-1:0] frames [PROCS][DEPTH];
  logic [4:0]                   frame_top [PROCS];

  int  gen_count = 0;
  int  beats_in = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  req_taken = 1'b0;
  logic quiet;

  assign quiet = (beats_in >= 350) && (beats_in < 450);

  round_robin_process_call_stacks dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  always #1 clk = ~clk;

  function automatic rrpcs_pkg::evt_t schedule_step(rrpcs_pkg::req_t r);
    rrpcs_pkg::evt_t              e;
    logic [rrpcs_pkg::PROC_W-1:0] p;
    logic [rrpcs_pkg::PROC_W-1:0] tail;
    logic [4:0]                   lvl;
    e = '0;
    tail = ring_front + ring_live[rrpcs_pkg::PROC_W-1:0];
    if (r.cmd == rrpcs_pkg::CMD_START) begin
      e.event_proc = r.proc_id;
      if (in_ring[r.proc_id]) begin
        e.event_res = rrpcs_pkg::EV_DUPLICATE;
      end else begin
        frame_top[r.proc_id] = '0;
        in_ring[r.proc_id] = 1'b1;
        ready_slot[tail] = r.proc_id;
        ring_live = ring_live + 1'b1;
        e.event_res = rrpcs_pkg::EV_ADDED;
      end
      return e;
    end
    if (ring_live == 0) begin
      e.event_res = rrpcs_pkg::EV_EMPTY;
      return e;
    end
    p = ready_slot[ring_front];
    lvl = frame_top[p];
    e.event_proc = p;
    if (r.cmd == rrpcs_pkg::CMD_RUN) begin
      if (lvl >= DEPTH) begin
        e.event_res = rrpcs_pkg::EV_FULL;
      end else begin
        frames[p][lvl[3:0]] = r.func_id;
        frame_top[p] = lvl + 1'b1;
        ready_slot[tail] = p;
        ring_front = ring_front + 1'b1;
        e.event_res = rrpcs_pkg::EV_CALLS;
        e.event_func = r.func_id;
      end
    end else if (lvl == 0) begin
      in_ring[p] = 1'b0;
      ring_front = ring_front + 1'b1;
      ring_live = ring_live - 1'b1;
      e.event_res = rrpcs_pkg::EV_ENDED;
    end else begin
      lvl = lvl - 1'b1;
      frame_top[p] = lvl;
      ready_slot[tail] = p;
      ring_front = ring_front + 1'b1;
      e.event_res = rrpcs_pkg::EV_RETURNS;
      e.event_func = frames[p][lvl[3:0]];
    end
    return e;
  endfunction

  task automatic queue_cmd(input logic [rrpcs_pkg::CMD_W-1:0] c,
                           input logic [rrpcs_pkg::PROC_W-1:0] p,
                           input logic [rrpcs_pkg::FUNC_W-1:0] f);
    rrpcs_pkg::req_t r;
    r.cmd = c;
    r.proc_id = p;
    r.func_id = f;
    cmd_backlog.push_back(r);
    gen_count++;
  endtask

  // a return beat, sometimes using the spare selector
  task automatic queue_return();
    queue_cmd(($urandom_range(0, 3) == 0) ? CMD_SPARE : rrpcs_pkg::CMD_RETURN,
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // stalled beat stays as it is
    end else if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
      req <= cmd_backlog.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off once the run is under way
  always @(negedge clk) begin
    if (!hold_done && beats_in >= 250) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      evt_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      evt_stall <= 1'b1;
    end else begin
      evt_stall <= !quiet && ($urandom_range(0, 99) < 34);
    end
  end

  // monitor: checks event beats, predicts on accepted commands
  always @(posedge clk) begin
    rrpcs_pkg::evt_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (evt_valid && !evt_stall) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event beat res %0d proc %0d func %0d",
                   $time, evt.event_res, evt.event_proc, evt.event_func);
          mismatches++;
        end else begin
          want = due_events.pop_front();
          if (evt.event_res !== want.event_res) begin
            $display("%0t: event_res expected %0d got %0d", $time, want.event_res,
                     evt.event_res);
            mismatches++;
          end
          if (evt.event_proc !== want.event_proc) begin
            $display("%0t: event_proc expected %0d got %0d", $time, want.event_proc,
                     evt.event_proc);
            mismatches++;
          end
          if (evt.event_func !== want.event_func) begin
            $display("%0t: event_func expected %0d got %0d", $time, want.event_func,
                     evt.event_func);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        due_events.push_back(schedule_step(req));
        beats_in <= beats_in + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n, push_pct, len, k, r;
    ring_front = '0;
    ring_live = '0;
    for (int i = 0; i < PROCS; i++) begin
      in_ring[i] = 1'b0;
      frame_top[i] = '0;
      ready_slot[i] = '0;
    end

    // empty ring, duplicate start, filling one stack to the top
    queue_cmd(rrpcs_pkg::CMD_RUN, 4'd3, 8'hA5);
    queue_cmd(CMD_SPARE, 4'd0, 8'h00);
    queue_cmd(rrpcs_pkg::CMD_RETURN, 4'd15, 8'hFF);
    queue_cmd(rrpcs_pkg::CMD_START, 4'd15, 8'h5A);
    queue_cmd(rrpcs_pkg::CMD_START, 4'd15, 8'h00);
    queue_cmd(rrpcs_pkg::CMD_RUN, 4'd0, 8'hFF);
    queue_cmd(rrpcs_pkg::CMD_RUN, 4'd15, 8'h00);
    for (int i = 2; i < DEPTH; i++)
      queue_cmd(rrpcs_pkg::CMD_RUN, 4'($urandom_range(0, 15)), 8'($urandom));
    queue_cmd(rrpcs_pkg::CMD_RUN, 4'd7, 8'h11);
    queue_cmd(CMD_SPARE, 4'd9, 8'h22);
    queue_cmd(rrpcs_pkg::CMD_START, 4'd0, 8'hFF);
    queue_cmd(rrpcs_pkg::CMD_RETURN, 4'd0, 8'h00);
    queue_cmd(rrpcs_pkg::CMD_RETURN, 4'd15, 8'hFF);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // random commands are queued only once everything so far has come out
    while (cmd_backlog.size() != 0 || req_valid || due_events.size() != 0)
      @(posedge clk);

    gen_count = 0;
    while (gen_count < RAND_ITEMS) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        queue_cmd(rrpcs_pkg::CMD_START, 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 55;
        default: push_pct = 30;
      endcase
      len = $urandom_range(15, 60);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5)
          queue_cmd(rrpcs_pkg::CMD_START, 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
        else if (r < push_pct)
          queue_cmd(rrpcs_pkg::CMD_RUN, 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
        else queue_return();
      end
      // wind down, usually ending some processes
      k = $urandom_range(0, 30);
      for (int i = 0; i < k; i++) queue_return();
    end

    while (cmd_backlog.size() != 0 || req_valid || due_events.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/rrpcs_pkg.sv
design/rrpcs_ram.sv
design/round_robin_process_call_stacks.sv
tb/testbench.sv
